>>> rtl/csv_field_tokenizer_macros.svh
// Assertion macros used by the CSV tokenizer checker.
`ifndef CSV_FIELD_TOKENIZER_MACROS_SVH
`define CSV_FIELD_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define CFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csv tokenizer check failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define CFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csv tokenizer check failed");

`endif

>>> rtl/cft_pkg.sv
// Package: widths, parser mode codes, result kinds and result type of the tokenizer.
package cft_pkg;

  localparam int unsigned MAX_FIELD = 1024;
  localparam int unsigned CAP_W     = 11;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned MODE_W    = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_FIELD);

  // parser modes
  localparam logic [MODE_W-1:0] MODE_START  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PLAIN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUOTED = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QMARK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLOSED = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DROP   = 3'd5;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMMA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOL   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERR   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_value;
    logic [CNT_W-1:0]  position;
    logic [CNT_W-1:0]  field_length;
  } cft_result_t;

  typedef struct packed {
    logic        vld;
    cft_result_t res;
  } cft_push_t;

endpackage

>>> rtl/cft_if.sv
// Valid/ready channel interfaces for the tokenizer input and result streams.
interface cft_in_if import cft_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              line_end;

  modport source (output valid, output char_byte, output line_end, input ready);
  modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

interface cft_out_if import cft_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_value;
  logic [CNT_W-1:0]  position;
  logic [CNT_W-1:0]  field_length;

  modport source (output valid, output kind, output char_value, output position,
                  output field_length, input ready);
  modport sink   (input valid, input kind, input char_value, input position,
                  input field_length, output ready);
endinterface

>>> rtl/csv_field_tokenizer.sv
// Top level of the streaming CSV field tokenizer.
//
// Takes one CSV line a character per transaction (line_end marks the end of the
// line) and gives at most one result per character: a kept field character with
// its position, a field end with the trimmed length and whether a comma or the
// line end closed it, or an error. One transaction is taken every clock cycle
// while ready is high; parser state updates on acceptance and any result is
// registered into a two-entry buffer (result register plus skid stage), which
// keeps input flowing while a result waits, so input ready drops only when two
// results are pending. field_capacity is written through cfg_we_i/cfg_data_i
// while the block is idle, which the user, not the block, ensures; values above
// 1024 act as 1024. After an error the rest of the line is dropped silently.
module csv_field_tokenizer import cft_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  cft_in_if.sink           in_i,
  cft_out_if.source        out_o
);

  logic [CAP_W-1:0] field_capacity_q;
  logic             space;
  cft_push_t        push;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      field_capacity_q <= cfg_data_i;
    end
  end

  // per-character decode and parser state
  cft_parse u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .field_capacity_i (field_capacity_q),
    .space_i          (space),
    .in_i             (in_i),
    .push_o           (push)
  );

  // result register and skid stage
  cft_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

>>> rtl/cft_parse.sv
// Parser state registers and per-character decode.
module cft_parse import cft_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CAP_W-1:0] field_capacity_i,
  input  logic             space_i,
  cft_in_if.sink           in_i,
  output cft_push_t        push_o
);

  logic [MODE_W-1:0] mode_q, mode_d, mode_nxt;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  kept_q, kept_d;

  logic              acc;
  logic              eol, comma, quote, blank;
  logic [CAP_W-1:0]  cap_eff;
  logic              full;
  logic              do_store, in_quotes, do_end, do_fail;
  cft_result_t       res;
  logic              res_vld;

  assign in_i.ready = space_i;
  assign acc        = in_i.valid && space_i;

  assign eol   = in_i.line_end;
  assign comma = !eol && (in_i.char_byte == CH_COMMA);
  assign quote = !eol && (in_i.char_byte == CH_QUOTE);
  assign blank = !eol && ((in_i.char_byte == CH_SPACE) || (in_i.char_byte == CH_TAB));

  assign cap_eff = (field_capacity_i > CAP_MAX) ? CAP_MAX : field_capacity_i;
  assign full    = ({1'b0, cnt_q} + CAP_W'(1)) >= cap_eff;

  // action decode
  always_comb begin
    mode_nxt  = mode_q;
    do_store  = 1'b0;
    in_quotes = 1'b0;
    do_end    = 1'b0;
    do_fail   = 1'b0;
    case (mode_q)
      MODE_START: begin
        if (eol || comma) begin
          do_end = 1'b1;
        end else if (blank) begin
          mode_nxt = MODE_START;
        end else if (quote) begin
          mode_nxt = MODE_QUOTED;
        end else begin
          mode_nxt = MODE_PLAIN;
          do_store = 1'b1;
        end
      end
      MODE_PLAIN: begin
        if (eol || comma) do_end = 1'b1;
        else              do_store = 1'b1;
      end
      MODE_QUOTED: begin
        if (eol) begin
          do_fail = 1'b1;
        end else if (quote) begin
          mode_nxt = MODE_QMARK;
        end else begin
          do_store  = 1'b1;
          in_quotes = 1'b1;
        end
      end
      MODE_QMARK: begin
        if (quote) begin
          mode_nxt  = MODE_QUOTED;
          do_store  = 1'b1;
          in_quotes = 1'b1;
        end else if (eol || comma) begin
          do_end = 1'b1;
        end else if (blank) begin
          mode_nxt = MODE_CLOSED;
        end else begin
          do_fail = 1'b1;
        end
      end
      MODE_CLOSED: begin
        if (eol || comma) do_end = 1'b1;
        else if (!blank)  do_fail = 1'b1;
      end
      default: begin
        mode_nxt = MODE_DROP;
      end
    endcase
  end

  // state update and result build
  always_comb begin
    mode_d  = mode_nxt;
    cnt_d   = cnt_q;
    kept_d  = kept_q;
    res_vld = 1'b0;
    res     = '0;
    if (do_store) begin
      res_vld = 1'b1;
      if (full) begin
        mode_d   = MODE_DROP;
        res.kind = KIND_ERR;
      end else begin
        cnt_d          = cnt_q + CNT_W'(1);
        if (in_quotes || !blank) kept_d = cnt_q + CNT_W'(1);
        res.kind       = KIND_CHAR;
        res.char_value = in_i.char_byte;
        res.position   = cnt_q;
      end
    end else if (do_end) begin
      res_vld          = 1'b1;
      res.kind         = eol ? KIND_EOL : KIND_COMMA;
      res.field_length = kept_q;
      mode_d           = MODE_START;
      cnt_d            = '0;
      kept_d           = '0;
    end else if (do_fail) begin
      res_vld  = 1'b1;
      res.kind = KIND_ERR;
      mode_d   = eol ? MODE_START : MODE_DROP;
      if (eol) begin
        cnt_d  = '0;
        kept_d = '0;
      end
    end else if ((mode_q == MODE_DROP) && eol) begin
      mode_d = MODE_START;
      cnt_d  = '0;
      kept_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      cnt_q  <= '0;
      kept_q <= '0;
    end else if (acc) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      kept_q <= kept_d;
    end
  end

  assign push_o.vld = acc && res_vld;
  assign push_o.res = res;

endmodule

>>> rtl/cft_out_buf.sv
// Result register with skid stage feeding the result channel.
module cft_out_buf import cft_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cft_push_t push_i,
  output logic      space_o,
  cft_out_if.source out_o
);

  logic        out_vld_q, skid_vld_q;
  cft_result_t out_q, skid_q;
  logic        free;

  assign space_o = !skid_vld_q;
  assign free    = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= push_i.vld;
      end
    end else if (push_i.vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      if (skid_vld_q)      out_q <= skid_q;
      else if (push_i.vld) out_q <= push_i.res;
    end else if (push_i.vld) begin
      skid_q <= push_i.res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.char_value   = out_q.char_value;
  assign out_o.position     = out_q.position;
  assign out_o.field_length = out_q.field_length;

endmodule

>>> rtl/cft_checker.sv
// Port-level checker for the tokenizer, bound to the top level.
`include "csv_field_tokenizer_macros.svh"

module cft_checker import cft_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [KIND_W-1:0] kind_i,
  input logic [CHAR_W-1:0] char_value_i,
  input logic [CNT_W-1:0]  position_i,
  input logic [CNT_W-1:0]  field_length_i
);

  logic is_char, ends_field;

  assign is_char    = (kind_i == KIND_CHAR);
  assign ends_field = (kind_i == KIND_COMMA) || (kind_i == KIND_EOL);

  // a stalled result holds
  `CFT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(kind_i))

  // input stalls only while a result is pending
  `CFT_ASSERT_NOW(a_stall_has_result, !in_ready_i, out_valid_i)

  // a result only shows up after an input transaction
  `CFT_ASSERT_NEXT(a_out_from_input, !out_valid_i && !(in_valid_i && in_ready_i), !out_valid_i)

  // non-character results carry no character or position
  `CFT_ASSERT_NOW(a_no_char, out_valid_i && !is_char, (char_value_i == '0) && (position_i == '0))

  // characters and errors carry no length
  `CFT_ASSERT_NOW(a_no_len, out_valid_i && !ends_field, field_length_i == '0)

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .char_value_i   (out_o.char_value),
  .position_i     (out_o.position),
  .field_length_i (out_o.field_length)
);
